/* rtl/cafu_pkg.sv */
// ----------------------------------------------------------------------------
// cafu_pkg
// Shared types and codes of the 8/16-bit alu and flag unit.
// ----------------------------------------------------------------------------
package cafu_pkg;

   localparam int unsigned OP_W   = 5;
   localparam int unsigned WORD_W = 16;
   localparam int unsigned STAT_W = 8;
   localparam int unsigned CSR_W  = 1;

   typedef enum logic [OP_W-1:0] {
      OP_ADC     = 5'd0,
      OP_AND     = 5'd1,
      OP_ASL_MEM = 5'd2,
      OP_ASL_ACC = 5'd3,
      OP_LSR_MEM = 5'd4,
      OP_LSR_ACC = 5'd5,
      OP_BIT     = 5'd6,
      OP_BIT_IMM = 5'd7,
      OP_CMP     = 5'd8,
      OP_CPX     = 5'd9,
      OP_CPY     = 5'd10,
      OP_DEC_MEM = 5'd11,
      OP_DEC_ACC = 5'd12,
      OP_DEX     = 5'd13,
      OP_DEY     = 5'd14,
      OP_INC_MEM = 5'd15,
      OP_INC_ACC = 5'd16,
      OP_INX     = 5'd17,
      OP_INY     = 5'd18,
      OP_LDA     = 5'd19,
      OP_LDX     = 5'd20,
      OP_LDY     = 5'd21,
      OP_CLC     = 5'd22,
      OP_SEC     = 5'd23,
      OP_CLV     = 5'd24,
      OP_CLI     = 5'd25,
      OP_CLD     = 5'd26,
      OP_SED     = 5'd27,
      OP_SEI     = 5'd28
   } op_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_ACC_NARROW   = 1'b0,
      CSR_INDEX_NARROW = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [WORD_W-1:0] operand;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] accumulator_out;
      logic [WORD_W-1:0] x_out;
      logic [WORD_W-1:0] y_out;
      logic [STAT_W-1:0] status_out;
      logic [WORD_W-1:0] memory_result;
   } rsp_type;

   typedef struct packed {
      logic n;
      logic v;
      logic d;
      logic i;
      logic z;
      logic c;
   } flags_type;

   typedef struct packed {
      logic [WORD_W-1:0] acc;
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
      flags_type         flags;
   } arch_type;

   typedef struct packed {
      logic acc_narrow;
      logic index_narrow;
   } mode_type;

endpackage

/* rtl/cpu_alu_flag_unit_8_16.sv */
// ----------------------------------------------------------------------------
// cpu_alu_flag_unit_8_16
// 8/16-bit alu and flag unit: accumulator, x, y and flags, one op per item.
// path: item accepted into the input register, then executed into the result register,
//    which raises result valid
// throughput: 1 item per cycle while the result side is not stalled; limited by the single
//    execute step that reads and writes the register file in the same cycle
// reset: synchronous; registers, flags and mode bits clear, both stages empty
// ----------------------------------------------------------------------------
module cpu_alu_flag_unit_8_16 (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  cafu_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output cafu_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cafu_pkg::CSR_W-1:0]    csr_index,
   input  logic                          csr_data
);
   import cafu_pkg::*;

   logic     stage_valid_ff;
   logic     stage_valid_in;
   req_type  stage_ff;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   rsp_type  rsp_ff;
   rsp_type  rsp_in;
   arch_type arch_ff;
   arch_type arch_in;
   mode_type mode_ff;
   mode_type mode_in;
   logic     req_take;
   logic     exec;

   assign exec      = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || exec;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign stage_valid_in = req_take || (stage_valid_ff && !exec);
   assign rsp_valid_in   = exec || (rsp_valid_ff && !rsp_ready);

   always_comb begin
      mode_in = mode_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_ACC_NARROW:   mode_in.acc_narrow   = csr_data;
            CSR_INDEX_NARROW: mode_in.index_narrow = csr_data;
            default:          mode_in = mode_ff;
         endcase
      end
   end

   cafu_exec u_exec (
      .op        (op_type'(stage_ff.operation)),
      .operand   (stage_ff.operand),
      .arch_cur  (arch_ff),
      .mode      (mode_ff),
      .arch_next (arch_in),
      .rsp       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         arch_ff        <= '0;
         mode_ff        <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         mode_ff        <= mode_in;
         if (exec) begin
            arch_ff <= arch_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_ff <= req_data;
      end
      if (exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !stage_valid_ff))
      else $error("stages not empty after reset");

   a_exec_fills: assert property (@(posedge clock) disable iff (reset)
      exec |=> rsp_valid_ff)
      else $error("executed item did not reach result register");

   a_memres_zero: assert property (@(posedge clock) disable iff (reset)
      (exec && !(stage_ff.operation == OP_ASL_MEM || stage_ff.operation == OP_LSR_MEM ||
                 stage_ff.operation == OP_DEC_MEM || stage_ff.operation == OP_INC_MEM))
      |=> (rsp_ff.memory_result == '0))
      else $error("memory result not zero for register op");

   a_acc_high_held: assert property (@(posedge clock) disable iff (reset)
      (exec && mode_ff.acc_narrow) |=> (arch_ff.acc[15:8] == $past(arch_ff.acc[15:8])))
      else $error("accumulator high byte changed in narrow mode");

endmodule

/* rtl/cafu_exec.sv */
// ----------------------------------------------------------------------------
// cafu_exec
// Execute logic: next register and flag state and the result item for one op.
// ----------------------------------------------------------------------------
module cafu_exec (
   input  cafu_pkg::op_type               op,
   input  logic [cafu_pkg::WORD_W-1:0]    operand,
   input  cafu_pkg::arch_type             arch_cur,
   input  cafu_pkg::mode_type             mode,
   output cafu_pkg::arch_type             arch_next,
   output cafu_pkg::rsp_type              rsp
);
   import cafu_pkg::*;

   // low byte only in narrow mode
   function automatic logic [WORD_W-1:0] fit(input logic [WORD_W-1:0] v, input logic narrow);
      fit = narrow ? {8'h00, v[7:0]} : v;
   endfunction

   function automatic logic top_bit(input logic [WORD_W-1:0] v, input logic narrow);
      top_bit = narrow ? v[7] : v[15];
   endfunction

   // returns {n, z}
   function automatic logic [1:0] nz(input logic [WORD_W-1:0] v, input logic narrow);
      logic [WORD_W-1:0] m;
      m  = fit(v, narrow);
      nz = {top_bit(m, narrow), (m == '0)};
   endfunction

   // high byte held in narrow mode
   function automatic logic [WORD_W-1:0] merge(input logic [WORD_W-1:0] reg_v,
                                               input logic [WORD_W-1:0] v,
                                               input logic narrow);
      merge = narrow ? {reg_v[15:8], v[7:0]} : v;
   endfunction

   // returns {n, z, c}
   function automatic logic [2:0] cmp(input logic [WORD_W-1:0] reg_v,
                                      input logic [WORD_W-1:0] v,
                                      input logic narrow);
      logic [WORD_W:0] diff;
      diff = {1'b0, fit(reg_v, narrow)} - {1'b0, fit(v, narrow)};
      cmp  = {nz(diff[WORD_W-1:0], narrow), ~diff[WORD_W]};
   endfunction

   logic              an;
   logic              xn;
   logic [WORD_W-1:0] a;
   logic [WORD_W-1:0] b;
   logic [WORD_W:0]   sum;
   logic [WORD_W-1:0] r;
   logic [WORD_W-1:0] memres;

   assign an = mode.acc_narrow;
   assign xn = mode.index_narrow;
   assign a  = fit(arch_cur.acc, an);
   assign b  = fit(operand, an);

   always_comb begin
      arch_next = arch_cur;
      memres    = '0;
      r         = '0;
      sum       = '0;
      case (op)
         OP_ADC: begin
            sum = {1'b0, a} + {1'b0, b} + {{WORD_W{1'b0}}, arch_cur.flags.c};
            r   = fit(sum[WORD_W-1:0], an);
            arch_next.flags.c = an ? sum[8] : sum[WORD_W];
            arch_next.flags.v = top_bit(~(a ^ b) & (a ^ r), an);
            {arch_next.flags.n, arch_next.flags.z} = nz(r, an);
            arch_next.acc = merge(arch_cur.acc, r, an);
         end
         OP_AND: begin
            r = a & b;
            {arch_next.flags.n, arch_next.flags.z} = nz(r, an);
            arch_next.acc = merge(arch_cur.acc, r, an);
         end
         OP_ASL_MEM: begin
            arch_next.flags.c = top_bit(b, an);
            memres = fit({b[WORD_W-2:0], 1'b0}, an);
            {arch_next.flags.n, arch_next.flags.z} = nz(memres, an);
         end
         OP_ASL_ACC: begin
            arch_next.flags.c = top_bit(a, an);
            r = fit({a[WORD_W-2:0], 1'b0}, an);
            {arch_next.flags.n, arch_next.flags.z} = nz(r, an);
            arch_next.acc = merge(arch_cur.acc, r, an);
         end
         OP_LSR_MEM: begin
            arch_next.flags.c = b[0];
            memres = {1'b0, b[WORD_W-1:1]};
            {arch_next.flags.n, arch_next.flags.z} = nz(memres, an);
         end
         OP_LSR_ACC: begin
            arch_next.flags.c = a[0];
            r = {1'b0, a[WORD_W-1:1]};
            {arch_next.flags.n, arch_next.flags.z} = nz(r, an);
            arch_next.acc = merge(arch_cur.acc, r, an);
         end
         OP_BIT: begin
            arch_next.flags.z = ((a & b) == '0);
            arch_next.flags.n = top_bit(b, an);
            arch_next.flags.v = an ? b[6] : b[14];
         end
         OP_BIT_IMM: begin
            arch_next.flags.z = ((a & b) == '0);
         end
         OP_CMP: begin
            {arch_next.flags.n, arch_next.flags.z, arch_next.flags.c} =
               cmp(arch_cur.acc, operand, an);
         end
         OP_CPX: begin
            {arch_next.flags.n, arch_next.flags.z, arch_next.flags.c} =
               cmp(arch_cur.x, operand, xn);
         end
         OP_CPY: begin
            {arch_next.flags.n, arch_next.flags.z, arch_next.flags.c} =
               cmp(arch_cur.y, operand, xn);
         end
         OP_DEC_MEM: begin
            memres = fit(b - 16'd1, an);
            {arch_next.flags.n, arch_next.flags.z} = nz(memres, an);
         end
         OP_DEC_ACC: begin
            r = fit(a - 16'd1, an);
            {arch_next.flags.n, arch_next.flags.z} = nz(r, an);
            arch_next.acc = merge(arch_cur.acc, r, an);
         end
         OP_DEX: begin
            r = fit(arch_cur.x - 16'd1, xn);
            {arch_next.flags.n, arch_next.flags.z} = nz(r, xn);
            arch_next.x = merge(arch_cur.x, r, xn);
         end
         OP_DEY: begin
            r = fit(arch_cur.y - 16'd1, xn);
            {arch_next.flags.n, arch_next.flags.z} = nz(r, xn);
            arch_next.y = merge(arch_cur.y, r, xn);
         end
         OP_INC_MEM: begin
            memres = fit(b + 16'd1, an);
            {arch_next.flags.n, arch_next.flags.z} = nz(memres, an);
         end
         OP_INC_ACC: begin
            r = fit(a + 16'd1, an);
            {arch_next.flags.n, arch_next.flags.z} = nz(r, an);
            arch_next.acc = merge(arch_cur.acc, r, an);
         end
         OP_INX: begin
            r = fit(arch_cur.x + 16'd1, xn);
            {arch_next.flags.n, arch_next.flags.z} = nz(r, xn);
            arch_next.x = merge(arch_cur.x, r, xn);
         end
         OP_INY: begin
            r = fit(arch_cur.y + 16'd1, xn);
            {arch_next.flags.n, arch_next.flags.z} = nz(r, xn);
            arch_next.y = merge(arch_cur.y, r, xn);
         end
         OP_LDA: begin
            {arch_next.flags.n, arch_next.flags.z} = nz(b, an);
            arch_next.acc = merge(arch_cur.acc, b, an);
         end
         OP_LDX: begin
            {arch_next.flags.n, arch_next.flags.z} = nz(operand, xn);
            arch_next.x = merge(arch_cur.x, operand, xn);
         end
         OP_LDY: begin
            {arch_next.flags.n, arch_next.flags.z} = nz(operand, xn);
            arch_next.y = merge(arch_cur.y, operand, xn);
         end
         OP_CLC: arch_next.flags.c = 1'b0;
         OP_SEC: arch_next.flags.c = 1'b1;
         OP_CLV: arch_next.flags.v = 1'b0;
         OP_CLI: arch_next.flags.i = 1'b0;
         OP_CLD: arch_next.flags.d = 1'b0;
         OP_SED: arch_next.flags.d = 1'b1;
         OP_SEI: arch_next.flags.i = 1'b1;
         // unused codes leave everything as it is
         default: arch_next = arch_cur;
      endcase
   end

   assign rsp.accumulator_out = arch_next.acc;
   assign rsp.x_out           = arch_next.x;
   assign rsp.y_out           = arch_next.y;
   assign rsp.status_out      = {arch_next.flags.n, arch_next.flags.v, an, xn,
                                 arch_next.flags.d, arch_next.flags.i,
                                 arch_next.flags.z, arch_next.flags.c};
   assign rsp.memory_result   = memres;

endmodule
